// File: src/cmr_pkg.sv
// Shared types, codes and default sizes for the chunked message reassembly core.
package cmr_pkg;

  // Default sizes
  localparam int DEF_MAX_CHUNKS       = 4;
  localparam int DEF_POINTS_PER_CHUNK = 5;
  localparam int DEF_MAX_POINTS       = 20;

  // Item kinds
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_POINT = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_STAGED = 3'd0;
  localparam logic [2:0] ST_ACCEPT = 3'd1;
  localparam logic [2:0] ST_REJECT = 3'd2;
  localparam logic [2:0] ST_RESET  = 3'd3;
  localparam logic [2:0] ST_READ   = 3'd4;

  // Input word
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] req_id;
    logic [7:0]  exercise_id;
    logic [7:0]  page_no;
    logic [7:0]  page_total;
    logic [2:0]  chunk_index;
    logic [2:0]  chunk_count;
    logic [2:0]  points_in_chunk;
    logic [2:0]  point_pos;
    logic [31:0] point_time;
    logic [31:0] point_value;
  } cmr_in_t;

  // Result word
  typedef struct packed {
    logic [2:0]  status;
    logic        complete;
    logic [2:0]  chunks_received;
    logic [4:0]  points_held;
    logic [31:0] read_time;
    logic [31:0] read_value;
  } cmr_out_t;

  // Point memory control
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } cmr_mem_ctl_t;

endpackage

// File: src/cmr_point_mem.sv
// Point store: registered-read memory of time/value pairs with per-slot valid bits.
module cmr_point_mem #(
  parameter int SLOTS = cmr_pkg::DEF_MAX_CHUNKS * cmr_pkg::DEF_POINTS_PER_CHUNK,
  parameter int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmr_pkg::cmr_mem_ctl_t ctl,
  input  logic [AW-1:0]        rd_addr,
  input  logic [AW-1:0]        wr_addr,
  input  logic [31:0]          wr_time,
  input  logic [31:0]          wr_value,
  output logic [31:0]          rd_time,
  output logic [31:0]          rd_value
);
  import cmr_pkg::*;

  logic [63:0]      mem_r [SLOTS];
  logic [SLOTS-1:0] vld_r;
  logic [63:0]      rd_data_r;
  logic             rd_vld_r;

  // Write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[wr_addr] <= {wr_time, wr_value};
    end
  end

  // Track written slots; unwritten slots read as zero
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      vld_r <= '0;
    end else if (ctl.wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem_r[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  assign rd_time  = rd_vld_r ? rd_data_r[63:32] : 32'd0;
  assign rd_value = rd_vld_r ? rd_data_r[31:0]  : 32'd0;

endmodule

// File: src/chunked_message_reassembly_core.sv
// Top level: chunk header checks, chunk table and point store sequencing.
//
//   channel  ports                         handshake
//   -------  ----------------------------  -----------------------------------
//   input    start, busy, in_data          word taken when start & !busy
//   result   out_strobe, out_data          one word per input, one cycle wide
//
// For each input word, the accept cycle issues the point memory
// read, the next cycle checks the word against the read data, writes the
// memory back and updates the chunk table. busy is high in that check cycle.
// The result shows on out_data the cycle after, while the next word may be
// accepted. Reset is synchronous; it and a clear word empty all state at once
// through the slot valid bits, so no clearing pass is needed. The result side
// cannot stall.
module chunked_message_reassembly_core #(
  parameter int MAX_CHUNKS       = cmr_pkg::DEF_MAX_CHUNKS,
  parameter int POINTS_PER_CHUNK = cmr_pkg::DEF_POINTS_PER_CHUNK,
  parameter int MAX_POINTS       = cmr_pkg::DEF_MAX_POINTS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  cmr_pkg::cmr_in_t in_data,
  output logic             out_strobe,
  output cmr_pkg::cmr_out_t out_data
);
  import cmr_pkg::*;

  localparam int SLOTS = MAX_CHUNKS * POINTS_PER_CHUNK;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW    = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int RW    = $clog2(MAX_CHUNKS + 1);
  localparam int TW    = $clog2(MAX_POINTS + 1);
  localparam int SW    = TW + 3;
  localparam logic [4:0]    MAXC = 5'(MAX_CHUNKS);
  localparam logic [4:0]    PPC  = 5'(POINTS_PER_CHUNK);
  localparam logic [SW-1:0] MAXP = SW'(MAX_POINTS);

  // Stage registers
  logic          valid_r;
  cmr_in_t       item_r;
  logic [AW-1:0] addr_r;
  logic          out_strobe_r, out_strobe_nxt;
  cmr_out_t      out_data_r, out_data_nxt;

  // Chunk table and header lock
  logic [15:0]   held_request_r, held_request_nxt;
  logic [7:0]    held_exercise_r, held_exercise_nxt;
  logic [7:0]    held_page_r, held_page_nxt;
  logic [7:0]    held_total_r, held_total_nxt;
  logic [2:0]    held_count_r, held_count_nxt;
  logic [RW-1:0] recv_r, recv_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic          chunk_bad_r, chunk_bad_nxt;
  logic [MAX_CHUNKS-1:0] seen_r, seen_nxt;
  logic [2:0]    counts_r [MAX_CHUNKS];
  logic [2:0]    counts_nxt [MAX_CHUNKS];

  // Memory interface
  cmr_mem_ctl_t  mem_ctl;
  logic [7:0]    acc_slot;
  logic [31:0]   rd_time, rd_value;

  // Stage decode
  logic          accept;
  logic [CW-1:0] cidx;
  logic          idx_ok, slot_ok, seen_hit, stage_pt, last_pt;
  logic          bad_now, hdr_bad, hdr_diff, ok;
  logic [2:0]    cnt_hit;
  logic [SW-1:0] budget;

  assign accept   = start && !busy;
  assign busy     = valid_r;
  assign acc_slot = 8'(in_data.chunk_index) * 8'(POINTS_PER_CHUNK) + 8'(in_data.point_pos);

  // Hold the accepted word for its check cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
      addr_r <= AW'(acc_slot);
    end
  end

  cmr_point_mem #(
    .SLOTS (SLOTS),
    .AW    (AW)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mem_ctl),
    .rd_addr  (AW'(acc_slot)),
    .wr_addr  (addr_r),
    .wr_time  (item_r.point_time),
    .wr_value (item_r.point_value),
    .rd_time  (rd_time),
    .rd_value (rd_value)
  );

  // Slot and chunk lookups for the held word
  assign cidx     = CW'(item_r.chunk_index);
  assign idx_ok   = 5'(item_r.chunk_index) < MAXC;
  assign slot_ok  = idx_ok && (5'(item_r.point_pos) < PPC);
  assign seen_hit = idx_ok && seen_r[cidx];
  assign cnt_hit  = counts_r[cidx];
  assign stage_pt = (item_r.points_in_chunk != 3'd0) &&
                    (item_r.point_pos < item_r.points_in_chunk);
  assign last_pt  = (item_r.points_in_chunk == 3'd0) ? (item_r.point_pos == 3'd0) :
                    (item_r.point_pos == item_r.points_in_chunk - 3'd1);

  // Point checks: an earlier bad point in the chunk, zero data, or mismatch against an accepted chunk
  assign bad_now = chunk_bad_r ||
                   (stage_pt && (item_r.point_time == 32'd0 || item_r.point_value == 32'd0)) ||
                   (stage_pt && slot_ok && seen_hit &&
                    (rd_time != item_r.point_time || rd_value != item_r.point_value));

  // Header limit checks
  assign hdr_bad = (item_r.req_id == 16'd0) ||
                   (5'(item_r.chunk_count) > MAXC) ||
                   (item_r.chunk_index >= item_r.chunk_count) ||
                   (5'(item_r.points_in_chunk) > PPC) ||
                   ((item_r.points_in_chunk == 3'd0) &&
                    !(item_r.page_total == 8'd0 && item_r.chunk_count == 3'd1 &&
                      item_r.chunk_index == 3'd0)) ||
                   ((item_r.page_total != 8'd0) && (item_r.page_no >= item_r.page_total));

  assign hdr_diff = (held_request_r != item_r.req_id) ||
                    (held_exercise_r != item_r.exercise_id) ||
                    (held_page_r != item_r.page_no) ||
                    (held_total_r != item_r.page_total) ||
                    (held_count_r != item_r.chunk_count);

  assign budget = SW'(total_r) + SW'(item_r.points_in_chunk);

  // Check, update and build the result
  always_comb begin
    held_request_nxt  = held_request_r;
    held_exercise_nxt = held_exercise_r;
    held_page_nxt     = held_page_r;
    held_total_nxt    = held_total_r;
    held_count_nxt    = held_count_r;
    recv_nxt          = recv_r;
    total_nxt         = total_r;
    chunk_bad_nxt     = chunk_bad_r;
    seen_nxt          = seen_r;
    counts_nxt        = counts_r;
    mem_ctl.rd_en     = accept;
    mem_ctl.wr_en     = 1'b0;
    mem_ctl.clr       = 1'b0;
    ok                = 1'b0;
    out_strobe_nxt    = valid_r;
    out_data_nxt      = '0;

    if (valid_r) begin
      unique case (item_r.kind)
        KIND_CLEAR: begin
          held_request_nxt  = '0;
          held_exercise_nxt = '0;
          held_page_nxt     = '0;
          held_total_nxt    = '0;
          held_count_nxt    = '0;
          recv_nxt          = '0;
          total_nxt         = '0;
          chunk_bad_nxt     = 1'b0;
          seen_nxt          = '0;
          for (int i = 0; i < MAX_CHUNKS; i++) begin
            counts_nxt[i] = 3'd0;
          end
          mem_ctl.clr         = 1'b1;
          out_data_nxt.status = ST_RESET;
        end
        KIND_POINT: begin
          // Stage the point into a fresh chunk
          mem_ctl.wr_en = stage_pt && slot_ok && !seen_hit;
          if (!last_pt) begin
            chunk_bad_nxt       = bad_now;
            out_data_nxt.status = ST_STAGED;
          end else begin
            chunk_bad_nxt = 1'b0;
            ok = !hdr_bad && !bad_now && ((recv_r == '0) || !hdr_diff);
            if (ok && recv_r == '0) begin
              held_request_nxt  = item_r.req_id;
              held_exercise_nxt = item_r.exercise_id;
              held_page_nxt     = item_r.page_no;
              held_total_nxt    = item_r.page_total;
              held_count_nxt    = item_r.chunk_count;
            end
            if (ok) begin
              if (seen_r[cidx]) begin
                ok = (cnt_hit == item_r.points_in_chunk);
              end else if (budget > MAXP) begin
                ok = 1'b0;
              end else begin
                counts_nxt[cidx] = item_r.points_in_chunk;
                total_nxt        = TW'(budget);
                seen_nxt[cidx]   = 1'b1;
                recv_nxt         = recv_r + RW'(1);
              end
            end
            out_data_nxt.status = ok ? ST_ACCEPT : ST_REJECT;
          end
        end
        default: begin
          // Read back a stored point; anything not held reads as zero
          out_data_nxt.status = ST_READ;
          if (slot_ok && seen_hit && (item_r.point_pos < cnt_hit)) begin
            out_data_nxt.read_time  = rd_time;
            out_data_nxt.read_value = rd_value;
          end
        end
      endcase
    end

    out_data_nxt.complete        = (recv_nxt == RW'(held_count_nxt));
    out_data_nxt.chunks_received = 3'(recv_nxt);
    out_data_nxt.points_held     = 5'(total_nxt);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_request_r  <= '0;
      held_exercise_r <= '0;
      held_page_r     <= '0;
      held_total_r    <= '0;
      held_count_r    <= '0;
      recv_r          <= '0;
      total_r         <= '0;
      chunk_bad_r     <= 1'b0;
      seen_r          <= '0;
      out_strobe_r    <= 1'b0;
      for (int i = 0; i < MAX_CHUNKS; i++) begin
        counts_r[i] <= 3'd0;
      end
    end else begin
      held_request_r  <= held_request_nxt;
      held_exercise_r <= held_exercise_nxt;
      held_page_r     <= held_page_nxt;
      held_total_r    <= held_total_nxt;
      held_count_r    <= held_count_nxt;
      recv_r          <= recv_nxt;
      total_r         <= total_nxt;
      chunk_bad_r     <= chunk_bad_nxt;
      seen_r          <= seen_nxt;
      out_strobe_r    <= out_strobe_nxt;
      counts_r        <= counts_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule
